[src/dti_pkg.sv]
`timescale 1ns / 1ps
package dti_pkg;

   typedef logic [4:0]         state_type;
   typedef logic signed [11:0] bias_type;
   typedef logic [1:0]         csr_index_type;

   localparam csr_index_type CSR_BASE_BIAS     = 2'd0;
   localparam csr_index_type CSR_STANDARD_BIAS = 2'd1;
   localparam csr_index_type CSR_DAYLIGHT_BIAS = 2'd2;

   localparam logic [15:0] YEAR_MIN = 16'd1601;
   localparam logic [15:0] YEAR_MAX = 16'd30827;

   // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for y below 43699
   localparam logic [31:0] DIV100_MUL   = 32'd5243;
   localparam int          DIV100_SHIFT = 19;

   // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x below 2**27 / 6
   localparam logic [31:0] DIV7_MUL   = 32'd19173962;
   localparam int          DIV7_SHIFT = 27;
   localparam logic [2:0]  WEEK_LEN   = 3'd7;

   localparam logic [24:0] DAYS_BEFORE_1601 = 25'd584388;
   localparam logic [31:0] DAYS_PER_YEAR    = 32'd365;
   localparam logic [31:0] MS_PER_DAY       = 32'd86400000;
   localparam logic [31:0] MS_PER_HOUR      = 32'd3600000;
   localparam logic [31:0] MS_PER_MINUTE    = 32'd60000;
   localparam logic [31:0] MS_PER_SECOND    = 32'd1000;
   localparam logic [31:0] TICKS_PER_MS     = 32'd10000;

   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2:                       len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
         default:                    len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] n;
      case (month)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

[src/dst_transition_instant.sv]
// steps: a legal absolute rule goes through CHECK, DIV, D1A, D1B, FW, FWR, DCHK, WD, M1 to M6,
//   SIGN, T1, T2 and DONE, a bad field from CHECK to DONE; a recurring rule adds WEEK for the weekly stepping
// requests: one request at a time, busy stays high until the result cycle ends, so a new
//   request is taken only once busy has dropped
// every large constant product goes through one shared 32x32 multiplier under a small sequencer
// reset (synchronous, active high) clears the sequencer and the three bias registers
`timescale 1ns / 1ps
module dst_transition_instant (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_target_year,
   input  logic [15:0] req_rule_year,
   input  logic [3:0]  req_rule_month,
   input  logic [4:0]  req_rule_day,
   input  logic [2:0]  req_rule_weekday,
   input  logic [4:0]  req_rule_hour,
   input  logic [5:0]  req_rule_minute,
   input  logic [5:0]  req_rule_second,
   input  logic [9:0]  req_rule_millisecond,
   output logic        rsp_strobe,
   output logic        rsp_valid_res,
   output logic [14:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [2:0]  rsp_out_weekday,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic [9:0]  rsp_out_millisecond,
   output logic [62:0] rsp_utc_ticks,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import dti_pkg::*;

   localparam state_type S_IDLE  = 5'd0;
   localparam state_type S_CHECK = 5'd1;
   localparam state_type S_DIV   = 5'd2;
   localparam state_type S_D1A   = 5'd3;
   localparam state_type S_D1B   = 5'd4;
   localparam state_type S_FW    = 5'd5;
   localparam state_type S_FWR   = 5'd6;
   localparam state_type S_WEEK  = 5'd7;
   localparam state_type S_DCHK  = 5'd8;
   localparam state_type S_WD    = 5'd9;
   localparam state_type S_M1    = 5'd10;
   localparam state_type S_M2    = 5'd11;
   localparam state_type S_M3    = 5'd12;
   localparam state_type S_M4    = 5'd13;
   localparam state_type S_M5    = 5'd14;
   localparam state_type S_M6    = 5'd15;
   localparam state_type S_SIGN  = 5'd16;
   localparam state_type S_T1    = 5'd17;
   localparam state_type S_T2    = 5'd18;
   localparam state_type S_DONE  = 5'd19;

   state_type state_ff;
   logic      ok_ff;
   bias_type  base_bias_ff;
   bias_type  standard_bias_ff;
   bias_type  daylight_bias_ff;

   // captured request
   logic        cmd_ff;
   logic        recur_ff;
   logic [15:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  rday_ff;
   logic [2:0]  wd_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [9:0]  ms_ff;

   // working registers
   logic [8:0]         q100_ff;
   logic               leap_ff;
   logic [4:0]         len_ff;
   logic [24:0]        d1_ff;
   logic [5:0]         day_ff;
   logic [4:0]         k_ff;
   logic [23:0]        days_ff;
   logic [2:0]         wday_ff;
   logic signed [51:0] sum_ff;
   logic [63:0]        tick_ff;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] prod_ff;

   logic [15:0]        sel_year;
   logic               bad_fields;
   logic [15:0]        q100_times;
   logic               r100_zero;
   logic               leap;
   logic [8:0]         pq;
   logic [14:0]        p_year;
   logic [24:0]        mod_x;
   logic [23:0]        q7;
   logic [26:0]        rem7;
   logic [2:0]         first_wd;
   logic [5:0]         day_init;
   logic signed [12:0] bias;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign sel_year   = (req_rule_year != 16'd0) ? req_rule_year : req_target_year;
   assign bad_fields = (year_ff < YEAR_MIN) || (year_ff > YEAR_MAX) ||
                       (month_ff == 4'd0) || (month_ff > 4'd12) ||
                       (hour_ff > 5'd23) || (minute_ff > 6'd59) ||
                       (second_ff > 6'd59) || (ms_ff > 10'd999);

   assign p_year     = 15'(year_ff - 16'd1);
   assign q100_times = 16'(q100_ff) * 16'd100;
   assign r100_zero  = (year_ff == q100_times);
   assign leap       = ((year_ff[1:0] == 2'd0) && !r100_zero) ||
                       (r100_zero && (q100_ff[1:0] == 2'd0));
   // (year - 1) / 100 drops by one when the year itself is a century
   assign pq         = r100_zero ? (q100_ff - 9'd1) : q100_ff;

   // first of the month while its weekday is worked out, the resolved date afterwards
   assign mod_x    = ((state_ff == S_FW) || (state_ff == S_FWR)) ? (d1_ff + 25'd1)
                                                                 : ({1'b0, days_ff} + 25'd1);
   assign q7       = prod_ff[DIV7_SHIFT +: 24];
   assign rem7     = {2'b00, mod_x} - (27'(q7) * 27'(WEEK_LEN));
   assign first_wd = rem7[2:0];
   assign day_init = 6'd1 + 6'(wd_ff) + ((first_wd > wd_ff) ? 6'(WEEK_LEN) : 6'd0)
                     - 6'(first_wd);

   assign bias = $signed({base_bias_ff[11], base_bias_ff}) +
                 (cmd_ff ? $signed({standard_bias_ff[11], standard_bias_ff})
                         : $signed({daylight_bias_ff[11], daylight_bias_ff}));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CHECK: begin
            mul_a = $signed({16'd0, year_ff});
            mul_b = $signed(DIV100_MUL);
         end
         S_DIV: begin
            mul_a = $signed({17'd0, p_year});
            mul_b = $signed(DAYS_PER_YEAR);
         end
         S_FW, S_WD: begin
            mul_a = $signed({7'd0, mod_x});
            mul_b = $signed(DIV7_MUL);
         end
         S_M1: begin
            mul_a = $signed({8'd0, days_ff});
            mul_b = $signed(MS_PER_DAY);
         end
         S_M2: begin
            mul_a = $signed({27'd0, hour_ff});
            mul_b = $signed(MS_PER_HOUR);
         end
         S_M3: begin
            mul_a = $signed({26'd0, minute_ff});
            mul_b = $signed(MS_PER_MINUTE);
         end
         S_M4: begin
            mul_a = $signed({26'd0, second_ff});
            mul_b = $signed(MS_PER_SECOND);
         end
         S_M5: begin
            mul_a = {{19{bias[12]}}, bias};
            mul_b = $signed(MS_PER_MINUTE);
         end
         S_SIGN: begin
            mul_a = $signed({1'b0, sum_ff[30:0]});
            mul_b = $signed(TICKS_PER_MS);
         end
         S_T1: begin
            mul_a = $signed({13'd0, sum_ff[49:31]});
            mul_b = $signed(TICKS_PER_MS);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         ok_ff            <= 1'b0;
         base_bias_ff     <= '0;
         standard_bias_ff <= '0;
         daylight_bias_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BASE_BIAS:     base_bias_ff     <= csr_data;
               CSR_STANDARD_BIAS: standard_bias_ff <= csr_data;
               CSR_DAYLIGHT_BIAS: daylight_bias_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (bad_fields) begin
                  ok_ff    <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV:  state_ff <= S_D1A;
            S_D1A:  state_ff <= S_D1B;
            S_D1B:  state_ff <= S_FW;
            S_FW:   state_ff <= S_FWR;
            S_FWR:  state_ff <= recur_ff ? S_WEEK : S_DCHK;
            S_WEEK: begin
               if (!((k_ff < rday_ff) && (7'(day_ff) + 7'(WEEK_LEN) <= 7'(len_ff)))) begin
                  state_ff <= S_DCHK;
               end
            end
            S_DCHK: begin
               if ((day_ff == 6'd0) || (day_ff > 6'(len_ff))) begin
                  ok_ff    <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_WD;
               end
            end
            S_WD:   state_ff <= S_M1;
            S_M1:   state_ff <= S_M2;
            S_M2:   state_ff <= S_M3;
            S_M3:   state_ff <= S_M4;
            S_M4:   state_ff <= S_M5;
            S_M5:   state_ff <= S_M6;
            S_M6:   state_ff <= S_SIGN;
            S_SIGN: begin
               // ticks are total milliseconds times a positive constant, so the sign carries
               if (sum_ff < 0) begin
                  ok_ff    <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_T1;
               end
            end
            S_T1:   state_ff <= S_T2;
            S_T2: begin
               ok_ff    <= 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_ff    <= req_cmd;
               recur_ff  <= (req_rule_year == 16'd0);
               year_ff   <= sel_year;
               month_ff  <= req_rule_month;
               rday_ff   <= req_rule_day;
               wd_ff     <= req_rule_weekday;
               hour_ff   <= req_rule_hour;
               minute_ff <= req_rule_minute;
               second_ff <= req_rule_second;
               ms_ff     <= req_rule_millisecond;
            end
         end
         S_DIV: begin
            q100_ff <= prod_ff[DIV100_SHIFT +: 9];
         end
         S_D1A: begin
            leap_ff <= leap;
            len_ff  <= month_length(month_ff) +
                       5'((month_ff == 4'd2) && leap);
            d1_ff   <= 25'(prod_ff[24:0]) + 25'(p_year >> 2) - 25'(pq) + 25'(pq >> 2);
         end
         S_D1B: begin
            d1_ff <= d1_ff + 25'(days_before_month(month_ff)) +
                     25'((month_ff > 4'd2) && leap_ff) - DAYS_BEFORE_1601;
         end
         S_FWR: begin
            day_ff <= recur_ff ? day_init : {1'b0, rday_ff};
            k_ff   <= 5'd1;
         end
         S_WEEK: begin
            if ((k_ff < rday_ff) && (7'(day_ff) + 7'(WEEK_LEN) <= 7'(len_ff))) begin
               day_ff <= day_ff + 6'(WEEK_LEN);
               k_ff   <= k_ff + 5'd1;
            end
         end
         S_DCHK: begin
            days_ff <= 24'(d1_ff + 25'(day_ff) - 25'd1);
         end
         S_WD: begin
            sum_ff <= '0;
         end
         S_M1: begin
            wday_ff <= rem7[2:0];
         end
         S_M2, S_M3, S_M4, S_M5: begin
            sum_ff <= sum_ff + $signed(prod_ff[51:0]);
         end
         S_M6: begin
            sum_ff <= sum_ff + $signed(prod_ff[51:0]) + $signed({42'd0, ms_ff});
         end
         S_T1: begin
            tick_ff <= prod_ff;
         end
         S_T2: begin
            tick_ff <= tick_ff + {prod_ff[32:0], 31'd0};
         end
         default: ;
      endcase
   end

   assign rsp_strobe          = (state_ff == S_DONE);
   assign rsp_valid_res       = ok_ff;
   assign rsp_out_year        = ok_ff ? year_ff[14:0] : '0;
   assign rsp_out_month       = ok_ff ? month_ff : '0;
   assign rsp_out_day         = ok_ff ? day_ff[4:0] : '0;
   assign rsp_out_weekday     = ok_ff ? wday_ff : '0;
   assign rsp_out_hour        = ok_ff ? hour_ff : '0;
   assign rsp_out_minute      = ok_ff ? minute_ff : '0;
   assign rsp_out_second      = ok_ff ? second_ff : '0;
   assign rsp_out_millisecond = ok_ff ? ms_ff : '0;
   assign rsp_utc_ticks       = ok_ff ? tick_ff[62:0] : '0;

`ifndef NO_ASSERTIONS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy && !$past(start && !busy)))
      else $error("result strobe without request in flight");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> ((rsp_utc_ticks == '0) && (rsp_out_year == '0)))
      else $error("failed result carries nonzero fields");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> ((rsp_out_day != '0) && (rsp_out_weekday <= 3'd6)))
      else $error("valid result with illegal day or weekday");
`endif

endmodule
